// ===== rtl/core/bale_pkg.sv =====
// bale_pkg: shared types and constants for the bounded array list engine
// used by bale_ctrl and bounded_array_list_engine_core; depends on nothing
`default_nettype none

package bale_pkg;

    // list capacity and field widths
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_W       = 7;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 3;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LEN_W-1:0] LEN_DEPTH = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_PUSH   = 3'd1,
        OP_ERASE  = 3'd2,
        OP_POP    = 3'd3,
        OP_FIND   = 3'd4,
        OP_MODIFY = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_RESP
    } t_state;

    // one result beat
    typedef struct packed {
        t_status           status;
        logic              found;
        logic [ADDR_W-1:0] found_index;
        logic [LEN_W-1:0]  list_length;
    } t_result;

    // element memory access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== rtl/core/bale_ram.sv =====
// bale_ram: generic simple dual-port ram, one write and one registered read port
// standalone, no package dependency
`default_nettype none

module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bale_ctrl.sv =====
// bale_ctrl: request sequencer, checks requests and walks the element memory
// depends on bale_pkg; drives one bale_ram instance through a t_ram_req
`default_nettype none

module bale_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire bale_pkg::t_op               i_in_op,
    input  wire logic [bale_pkg::POS_W-1:0]  i_in_position,
    input  wire logic signed [bale_pkg::VAL_W-1:0] i_in_value,
    output      logic                        o_res_valid,
    input  wire logic                        i_res_ready,
    output      bale_pkg::t_result           o_res,
    output      bale_pkg::t_ram_req          o_ram_req,
    input  wire logic [bale_pkg::VAL_W-1:0]  i_ram_rdata
);
    import bale_pkg::*;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_count, n_count;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic [LEN_W-1:0]  r_idx, n_idx;
    t_op               r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [VAL_W-1:0]  r_val, n_val;
    t_status           r_status, n_status;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_fidx, n_fidx;
    logic [LEN_W-1:0]  idx_m1;
    logic [POS_W-1:0]  put_pos;

    assign idx_m1  = r_idx - LEN_ONE;
    assign put_pos = (r_op == OP_PUSH) ? r_count : r_pos;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_idx      <= n_idx;
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_status   <= n_status;
        r_found    <= n_found;
        r_fidx     <= n_fidx;
    end

    // next state, memory accesses and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_idx      = r_idx;
        n_op       = r_op;
        n_pos      = r_pos;
        n_val      = r_val;
        n_status   = r_status;
        n_found    = r_found;
        n_fidx     = r_fidx;
        o_ram_req  = '0;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_in_op;
                    n_pos   = i_in_position;
                    n_val   = i_in_value;
                    n_state = S_EXEC;
                end
            end

            // check the request, finish the single-step ones
            S_EXEC: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_fidx   = '0;
                n_pend   = 1'b0;
                n_state  = S_RESP;
                case (r_op)
                    OP_INSERT, OP_PUSH: begin
                        if (put_pos > r_count) begin
                            n_status = ST_BAD;
                        end else if (r_count >= LEN_DEPTH) begin
                            n_status = ST_FULL;
                        end else begin
                            n_pos   = put_pos;
                            n_idx   = r_count;
                            n_state = S_SHIFT_UP;
                        end
                    end
                    OP_ERASE: begin
                        if (r_pos >= r_count) begin
                            n_status = ST_BAD;
                        end else begin
                            n_idx   = r_pos + LEN_ONE;
                            n_state = S_SHIFT_DN;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_BAD;
                        end else begin
                            n_count = r_count - LEN_ONE;
                        end
                    end
                    OP_FIND: begin
                        n_idx   = '0;
                        n_state = S_SEARCH;
                    end
                    OP_MODIFY: begin
                        if (r_pos >= r_count) begin
                            n_status = ST_BAD;
                        end else begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_pos[ADDR_W-1:0];
                            o_ram_req.wdata = r_val;
                        end
                    end
                    default: begin
                        n_status = ST_BAD;
                    end
                endcase
            end

            // move entries up from the tail, then place the new value
            S_SHIFT_UP: begin
                if (r_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_pend_idx;
                    o_ram_req.wdata = i_ram_rdata;
                end
                if (r_idx > r_pos) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = idx_m1[ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_pend_idx      = r_idx[ADDR_W-1:0];
                    n_idx           = idx_m1;
                end else if (!r_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_pos[ADDR_W-1:0];
                    o_ram_req.wdata = r_val;
                    n_count         = r_count + LEN_ONE;
                    n_state         = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end

            // move entries down over the erased one
            S_SHIFT_DN: begin
                if (r_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_pend_idx;
                    o_ram_req.wdata = i_ram_rdata;
                end
                if (r_idx < r_count) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_idx[ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_pend_idx      = idx_m1[ADDR_W-1:0];
                    n_idx           = r_idx + LEN_ONE;
                end else if (!r_pend) begin
                    n_count = r_count - LEN_ONE;
                    n_state = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end

            // linear search from index zero, stop on the first match
            S_SEARCH: begin
                if (r_pend && (i_ram_rdata == r_val)) begin
                    n_found = 1'b1;
                    n_fidx  = r_pend_idx;
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                end else if (r_idx < r_count) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_idx[ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_pend_idx      = r_idx[ADDR_W-1:0];
                    n_idx           = r_idx + LEN_ONE;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_RESP;
                    end
                end
            end

            // hand the result to the output register
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status      = r_status;
    assign o_res.found       = r_found;
    assign o_res.found_index = r_fidx;
    assign o_res.list_length = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_array_list_engine_core.sv =====
// Bounded array list engine: ordered list of up to 64 signed 32-bit values.
// Slave channel s_axis_*: one request beat, tuser = operation (0 insert,
// 1 push_back, 2 erase, 3 pop_back, 4 find, 5 modify), tdata = position, value.
// Master channel m_axis_*: exactly one result beat per request, tuser = status
// (0 ok, 1 bad position / empty / unknown operation, 2 full), tdata = found,
// found_index, list_length (length after the operation).
// One request is worked at a time; s_axis_tready is high only while the
// sequencer is idle. Pop_back, modify and rejected requests finish in the
// check state; insert and push_back move the entries from the tail up to the
// position, then write the value; erase moves the entries above the position
// down; find reads from index zero until a match or the end of the list. The
// element memory has one write and one registered read port, so a shift moves
// one entry per cycle, and a search compares one entry per cycle.
// The result sits in an output register, so the next request is taken while
// the previous result waits; a stalled receiver holds the result there and,
// once a second result is ready, stalls the sequencer until the beat is taken.
// Synchronous active-low reset empties the list and drops any pending beat;
// memory contents are not cleared, as only entries below the length are read.
`default_nettype none

module bounded_array_list_engine_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // [6:0] position, [38:7] value, [39] zero fill
    input  wire logic [bale_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] operation
    input  wire logic [bale_pkg::OP_W-1:0]           s_axis_tuser,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] found, [6:1] found_index, [13:7] list_length, [15:14] zero fill
    output      logic [bale_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output      logic [bale_pkg::STAT_W-1:0]         m_axis_tuser
);
    import bale_pkg::*;

    t_ram_req         ram_req;
    logic [VAL_W-1:0] ram_rdata;
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             r_out_valid;
    t_result          r_out;

    bale_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_op       (t_op'(s_axis_tuser)),
        .i_in_position (s_axis_tdata[POS_W-1:0]),
        .i_in_value    (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_ram_req     (ram_req),
        .i_ram_rdata   (ram_rdata)
    );

    bale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    // result beat packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, r_out.list_length, r_out.found_index, r_out.found};

endmodule

`default_nettype wire

// ===== rtl/core/bale_checker.sv =====
// bale_checker: port-level assertions for the bounded array list engine core
// bound to bounded_array_list_engine_core; no package dependency
`default_nettype none

module bale_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // length never exceeds capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:7] <= 7'd64)
        else $error("list length beyond capacity");

    // a found value comes with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == 2'd0)
        else $error("found with error status");

    // index is zero unless found, and a found index lies inside the list
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] && m_axis_tdata[6:1] == 6'd0) ||
            (m_axis_tdata[0] && {1'b0, m_axis_tdata[6:1]} < m_axis_tdata[13:7]))
        else $error("found index inconsistent");

endmodule

bind bounded_array_list_engine_core bale_checker u_bale_checker (.*);

`default_nettype wire
